// ===== hw/rtl/joint_motion_sound_trigger_defines.svh =====
// ----------------------------------------------------------------------------
// joint motion sound trigger assertion macros
// shared property templates for the checker, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef JOINT_MOTION_SOUND_TRIGGER_DEFINES_SVH
`define JOINT_MOTION_SOUND_TRIGGER_DEFINES_SVH

// same-cycle implication
`define JMST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jmst same-cycle check failed");

// next-cycle implication
`define JMST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jmst next-cycle check failed");

`endif

// ===== hw/rtl/jmst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_pkg
// types, register indexes and helpers of the joint motion sound trigger
// ----------------------------------------------------------------------------
package jmst_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_LOWER_BOUND    = 3'd0;
  localparam logic [2:0] REG_UPPER_BOUND    = 3'd1;
  localparam logic [2:0] REG_MOVEMENT_PARAM = 3'd2;
  localparam logic [2:0] REG_LOWER_PARAM    = 3'd3;
  localparam logic [2:0] REG_UPPER_PARAM    = 3'd4;
  localparam logic [2:0] REG_SOUNDS_EN      = 3'd5;

  // reset value of a sound parameter set: gain 1.0, max gain full, pitch factor 0
  localparam logic [63:0] PARAMS_RESET = 64'h0100_FFFF_0000_FFFF;
  // unity in Q8.8
  localparam logic [32:0] ONE_Q8_8     = 33'h100;
  localparam logic [32:0] SAT16        = 33'h0_0000_FFFF;
  localparam logic [31:0] SPEED_SAT    = 32'hFFFF_FFFF;

  // number of multiplier operations per item (movement and limit, gain and pitch)
  localparam logic [2:0] MUL_OPS = 3'd4;

  typedef struct packed {
    logic signed [31:0] position;
    logic        [31:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] speed;
    logic        movement_start;
    logic        movement_stop;
    logic        movement_update;
    logic [15:0] movement_gain;
    logic [15:0] movement_pitch;
    logic        lower_hit;
    logic        upper_hit;
    logic [15:0] limit_gain;
    logic [15:0] limit_pitch;
  } out_item_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } jmst_state_t;

  // saturate to 16 bits, then clamp to the configured maximum
  function automatic logic [15:0] clamp_q88(input logic [32:0] v, input logic [15:0] mx);
    logic [32:0] s;
    begin
      s = (v > SAT16) ? SAT16 : v;
      clamp_q88 = (s[15:0] > mx) ? mx : s[15:0];
    end
  endfunction

endpackage

// ===== hw/rtl/joint_motion_sound_trigger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_motion_sound_trigger
// speed, movement sound and limit sound events for one slider or hinge joint
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one position sample and its
//   step time. out channel (out_valid/out_ready/out_data) returns one result
//   item per input item: speed, movement start/stop/update with gain and
//   pitch, and the lower/upper limit one-shot events with their gain/pitch.
//   cfg_wr_en/cfg_index/cfg_wdata write the bounds, the three parameter sets
//   and the sound enables; write only while no item is in flight.
// Sequence:
//   an item passes the bit-serial divider, then four products on the shared
//   multiplier, then the handoff to the output register. No motion or an
//   overflowing speed skips the divide. One item is worked on at a time;
//   in_ready is high only while the sequencer is idle, so a new item is
//   taken only once the last one has been handed off to the output register.
// Reset: synchronous, active low; clears the registers to their defaults,
//   the last position and the running flags, and drops out_valid.
// Stall: a finished result waits in the output register; the next item can
//   be accepted and computed meanwhile, and its result waits until the
//   output register is taken.
// ----------------------------------------------------------------------------
module joint_motion_sound_trigger (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jmst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jmst_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);

  // configuration registers
  logic signed [31:0] lower_bound_r;
  logic signed [31:0] upper_bound_r;
  logic [63:0]        movement_params_r;
  logic [63:0]        lower_params_r;
  logic [63:0]        upper_params_r;
  logic [2:0]         sounds_en_r;

  // joint state
  logic signed [31:0] last_pos_r;
  logic               mrun_r, lrun_r, urun_r;

  // sequencer and work registers
  jmst_pkg::jmst_state_t state_r, state_nxt;
  logic signed [31:0] pos_r;
  logic [31:0]        speed_r;
  logic [2:0]         mul_idx_r;
  logic [15:0]        m_gain_r, m_pitch_r, l_gain_r, l_pitch_r;

  logic                out_valid_r;
  jmst_pkg::out_item_t out_data_r;

  // sequencer outputs
  logic accept;
  logic div_start;
  logic load_out;

  jmst_pkg::div_res_t div_res;
  logic [32:0]        diff;
  logic [31:0]        abs_diff;
  logic [15:0]        mul_b;
  logic [47:0]        prod;
  logic [32:0]        prod_hi;
  logic [15:0]        gain_c, pitch_c;

  logic        moving;
  logic        m_start, m_stop, m_upd;
  logic        l_fire, u_fire;
  logic        lrun_upd, urun_upd;
  logic [63:0] lim_params;
  logic [15:0] cap_max;
  logic [15:0] cap_val;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r     <= '0;
      upper_bound_r     <= '0;
      movement_params_r <= jmst_pkg::PARAMS_RESET;
      lower_params_r    <= jmst_pkg::PARAMS_RESET;
      upper_params_r    <= jmst_pkg::PARAMS_RESET;
      sounds_en_r       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jmst_pkg::REG_LOWER_BOUND:    lower_bound_r     <= signed'(cfg_wdata[31:0]);
        jmst_pkg::REG_UPPER_BOUND:    upper_bound_r     <= signed'(cfg_wdata[31:0]);
        jmst_pkg::REG_MOVEMENT_PARAM: movement_params_r <= cfg_wdata;
        jmst_pkg::REG_LOWER_PARAM:    lower_params_r    <= cfg_wdata;
        jmst_pkg::REG_UPPER_PARAM:    upper_params_r    <= cfg_wdata;
        jmst_pkg::REG_SOUNDS_EN:      sounds_en_r       <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // absolute position change
  assign diff     = {in_data.position[31], in_data.position} - {last_pos_r[31], last_pos_r};
  assign abs_diff = diff[32] ? 32'(-diff) : diff[31:0];

  jmst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (abs_diff),
    .divisor  (in_data.step_time),
    .res      (div_res)
  );

  // event decisions from the finished speed
  assign moving  = speed_r != 32'h0;
  assign m_start = sounds_en_r[0] && moving && !mrun_r;
  assign m_stop  = sounds_en_r[0] && !moving && mrun_r;
  assign m_upd   = sounds_en_r[0] && moving;
  assign u_fire  = sounds_en_r[2] && moving && (pos_r > upper_bound_r) && !urun_r;
  assign l_fire  = sounds_en_r[1] && moving && (pos_r < lower_bound_r) && !lrun_r;
  // lower limit wins when both fire
  assign lim_params = l_fire ? lower_params_r : upper_params_r;

  // running flags after this item; a disabled sound holds its flag
  always_comb begin
    urun_upd = urun_r;
    if (sounds_en_r[2]) begin
      if (u_fire) begin
        urun_upd = 1'b1;
      end else if (pos_r <= upper_bound_r) begin
        urun_upd = 1'b0;
      end
    end
    lrun_upd = lrun_r;
    if (sounds_en_r[1]) begin
      if (l_fire) begin
        lrun_upd = 1'b1;
      end else if (pos_r >= lower_bound_r) begin
        lrun_upd = 1'b0;
      end
    end
  end

  // multiplier operand: movement gain, movement pitch, limit gain, limit pitch
  always_comb begin
    case (mul_idx_r)
      3'd0:    mul_b = movement_params_r[63:48];
      3'd1:    mul_b = movement_params_r[31:16];
      3'd2:    mul_b = lim_params[63:48];
      3'd3:    mul_b = lim_params[31:16];
      default: mul_b = 16'h0;
    endcase
  end

  jmst_mul u_mul (
    .clk    (clk),
    .op_a   (speed_r),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // clamp the product issued in the cycle before
  always_comb begin
    case (mul_idx_r)
      3'd1:    cap_max = movement_params_r[47:32];
      3'd2:    cap_max = movement_params_r[15:0];
      3'd3:    cap_max = lim_params[47:32];
      default: cap_max = lim_params[15:0];
    endcase
  end

  assign prod_hi = {1'b0, prod[47:16]};
  assign gain_c  = jmst_pkg::clamp_q88(prod_hi, cap_max);
  assign pitch_c = jmst_pkg::clamp_q88(prod_hi + jmst_pkg::ONE_Q8_8, cap_max);
  assign cap_val = mul_idx_r[0] ? gain_c : pitch_c;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jmst_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = jmst_pkg::ST_DIV;
      end
      jmst_pkg::ST_DIV: begin
        if (div_res.done) state_nxt = jmst_pkg::ST_MUL;
      end
      jmst_pkg::ST_MUL: begin
        if (mul_idx_r == jmst_pkg::MUL_OPS) state_nxt = jmst_pkg::ST_DONE;
      end
      jmst_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = jmst_pkg::ST_IDLE;
      end
      default: state_nxt = jmst_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    accept    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      jmst_pkg::ST_IDLE: begin
        accept    = in_valid;
        div_start = in_valid;
      end
      jmst_pkg::ST_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  assign in_ready = state_r == jmst_pkg::ST_IDLE;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jmst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
      mrun_r      <= 1'b0;
      lrun_r      <= 1'b0;
      urun_r      <= 1'b0;
      mul_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == jmst_pkg::ST_DIV) begin
        mul_idx_r <= '0;
      end else if (state_r == jmst_pkg::ST_MUL) begin
        mul_idx_r <= mul_idx_r + 3'd1;
      end
      if (load_out) begin
        last_pos_r <= pos_r;
        if (m_start) mrun_r <= 1'b1;
        if (m_stop)  mrun_r <= 1'b0;
        lrun_r <= lrun_upd;
        urun_r <= urun_upd;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (accept) pos_r <= in_data.position;
    if (state_r == jmst_pkg::ST_DIV && div_res.done) speed_r <= div_res.quot;
    if (state_r == jmst_pkg::ST_MUL) begin
      case (mul_idx_r)
        3'd1:    m_gain_r  <= cap_val;
        3'd2:    m_pitch_r <= cap_val;
        3'd3:    l_gain_r  <= cap_val;
        3'd4:    l_pitch_r <= cap_val;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.speed           <= speed_r;
      out_data_r.movement_start  <= m_start;
      out_data_r.movement_stop   <= m_stop;
      out_data_r.movement_update <= m_upd;
      out_data_r.movement_gain   <= m_upd ? m_gain_r : 16'h0;
      out_data_r.movement_pitch  <= m_upd ? m_pitch_r : 16'h0;
      out_data_r.lower_hit       <= l_fire;
      out_data_r.upper_hit       <= u_fire;
      out_data_r.limit_gain      <= (l_fire || u_fire) ? l_gain_r : 16'h0;
      out_data_r.limit_pitch     <= (l_fire || u_fire) ? l_pitch_r : 16'h0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/jmst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_div
// restoring divider, one quotient bit a cycle: (dividend << 16) / divisor,
// saturated to 32 bits; a zero dividend or an overflow sets the result
// directly, without the restoring steps
module jmst_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        dividend,
  input  logic [31:0]        divisor,
  output jmst_pkg::div_res_t res
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] trial;
  logic        fits;
  logic        ovf;

  // one restoring step
  assign trial = {rem_r, dvd_r[31]};
  assign fits  = trial >= {1'b0, dsr_r};
  // quotient would not fit in 32 bits (also covers a zero divisor)
  assign ovf   = (divisor[31:16] == 16'h0) && (dividend >= {divisor[15:0], 16'h0});

  // next values
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      if (dividend == 32'h0) begin
        quot_nxt = 32'h0;
        done_nxt = 1'b1;
      end else if (ovf) begin
        quot_nxt = jmst_pkg::SPEED_SAT;
        done_nxt = 1'b1;
      end else begin
        // upper 16 dividend bits only give zero quotient bits
        busy_nxt = 1'b1;
        cnt_nxt  = 5'd0;
        rem_nxt  = {16'h0, dividend[31:16]};
        dvd_nxt  = {dividend[15:0], 16'h0};
        dsr_nxt  = divisor;
        quot_nxt = 32'h0;
      end
    end else if (busy_r) begin
      rem_nxt  = fits ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
      dvd_nxt  = {dvd_r[30:0], 1'b0};
      quot_nxt = {quot_r[30:0], fits};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

// ===== hw/rtl/jmst_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_mul
// shared 32 x 16 multiplier with a registered product
// ----------------------------------------------------------------------------
module jmst_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [15:0] op_b,
  output logic [47:0] prod_r
);

  // product of speed and a Q8.8 factor, ready in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= 48'(op_a) * 48'(op_b);
  end

endmodule

// ===== hw/rtl/jmst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_checker
// port-level checks of the joint motion sound trigger, bound to the top level
// ----------------------------------------------------------------------------
`include "joint_motion_sound_trigger_defines.svh"

module jmst_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input jmst_pkg::out_item_t out_data
);

  // a stalled result holds
  `JMST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item at a time: busy right after an item is taken
  `JMST_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // start and stop never together, and start only with a movement update
  `JMST_ASSERT_IMP(a_start_stop, out_valid && out_data.movement_start,
                   !out_data.movement_stop && out_data.movement_update)

  // no motion means no update and no limit event
  `JMST_ASSERT_IMP(a_still, out_valid && (out_data.speed == 32'h0),
                   !out_data.movement_update && !out_data.lower_hit && !out_data.upper_hit)

  // quiet limit sounds report zero limit gain and pitch
  `JMST_ASSERT_IMP(a_quiet_zero, out_valid && !out_data.lower_hit && !out_data.upper_hit,
                   (out_data.limit_gain == 16'h0) && (out_data.limit_pitch == 16'h0))

endmodule

bind joint_motion_sound_trigger jmst_port_checks u_jmst_port_checks (.*);

// ===== verif/jmst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmst_checker
// Watches the configuration port and both channels of the joint motion sound
// trigger. It keeps its own copy of the registers, the last position and the
// running flags. For every accepted input item it works out the speed, the
// movement sound events and the limit sound events, and queues the result.
// Every accepted result is checked field by field against the oldest queued
// one. Mismatches and unexpected results are counted for the top.
// ----------------------------------------------------------------------------
module jmst_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  jmst_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  jmst_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  output int                  fail_count,
  output int                  events_pending
);
  import jmst_pkg::*;

  // shadow registers
  logic signed [31:0] lower_lim;
  logic signed [31:0] upper_lim;
  logic [63:0]        move_set;
  logic [63:0]        lower_set;
  logic [63:0]        upper_set;
  logic [2:0]         enables;

  // joint state
  logic signed [31:0] prev_pos;
  logic               move_on;
  logic               lower_on;
  logic               upper_on;

  out_item_t predicted_sounds[$];

  // gain: speed times gain factor, saturated to 16 bits, then capped
  function automatic logic [15:0] sound_gain(input logic [31:0] spd, input logic [63:0] p);
    logic [63:0] g;
    g = ({32'd0, spd} * {48'd0, p[63:48]}) >> 16;
    if (g > 64'hFFFF) g = 64'hFFFF;
    if (g > {48'd0, p[47:32]}) g = {48'd0, p[47:32]};
    return g[15:0];
  endfunction

  // pitch: unity plus speed times pitch factor, saturated, then capped
  function automatic logic [15:0] sound_pitch(input logic [31:0] spd, input logic [63:0] p);
    logic [63:0] q;
    q = 64'h100 + (({32'd0, spd} * {48'd0, p[31:16]}) >> 16);
    if (q > 64'hFFFF) q = 64'hFFFF;
    if (q > {48'd0, p[15:0]}) q = {48'd0, p[15:0]};
    return q[15:0];
  endfunction

  // sound events caused by one position sample, updates the joint state
  function automatic out_item_t compute_sound_events(input in_item_t it);
    logic signed [32:0] diff;
    logic [63:0]        travel;
    logic [63:0]        quo;
    logic [31:0]        spd;
    logic               moving;
    out_item_t          r;
    r = '0;
    diff = {it.position[31], it.position} - {prev_pos[31], prev_pos};
    travel = diff[32] ? {31'd0, -diff} : {31'd0, diff};
    // zero step time saturates any change
    if (it.step_time == 32'd0) begin
      spd = (travel != 64'd0) ? SPEED_SAT : 32'd0;
    end else begin
      quo = (travel << 16) / {32'd0, it.step_time};
      spd = (quo > 64'hFFFF_FFFF) ? SPEED_SAT : quo[31:0];
    end
    moving = (spd != 32'd0);
    r.speed = spd;

    // looping movement sound
    if (enables[0]) begin
      if (!moving && move_on) begin
        r.movement_stop = 1'b1;
        move_on = 1'b0;
      end else if (moving && !move_on) begin
        r.movement_start = 1'b1;
        move_on = 1'b1;
      end
      if (moving) begin
        r.movement_update = 1'b1;
        r.movement_gain = sound_gain(spd, move_set);
        r.movement_pitch = sound_pitch(spd, move_set);
      end
    end

    // upper limit one-shot
    if (enables[2]) begin
      if (moving && it.position > upper_lim && !upper_on) begin
        r.upper_hit = 1'b1;
        upper_on = 1'b1;
        r.limit_gain = sound_gain(spd, upper_set);
        r.limit_pitch = sound_pitch(spd, upper_set);
      end else if (it.position <= upper_lim) begin
        upper_on = 1'b0;
      end
    end

    // lower limit one-shot, its gain and pitch win when both fire
    if (enables[1]) begin
      if (moving && it.position < lower_lim && !lower_on) begin
        r.lower_hit = 1'b1;
        lower_on = 1'b1;
        r.limit_gain = sound_gain(spd, lower_set);
        r.limit_pitch = sound_pitch(spd, lower_set);
      end else if (it.position >= lower_lim) begin
        lower_on = 1'b0;
      end
    end

    prev_pos = it.position;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // track writes and items, compare results
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      lower_lim = '0;
      upper_lim = '0;
      move_set = PARAMS_RESET;
      lower_set = PARAMS_RESET;
      upper_set = PARAMS_RESET;
      enables = '0;
      prev_pos = '0;
      move_on = 1'b0;
      lower_on = 1'b0;
      upper_on = 1'b0;
      predicted_sounds.delete();
      events_pending = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LOWER_BOUND:    lower_lim = cfg_wdata[31:0];
          REG_UPPER_BOUND:    upper_lim = cfg_wdata[31:0];
          REG_MOVEMENT_PARAM: move_set = cfg_wdata;
          REG_LOWER_PARAM:    lower_set = cfg_wdata;
          REG_UPPER_PARAM:    upper_set = cfg_wdata;
          REG_SOUNDS_EN:      enables = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (predicted_sounds.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with none expected, expected nothing, got %0h",
                   $time, out_data);
        end else begin
          want = predicted_sounds.pop_front();
          check_field("speed", want.speed, out_data.speed);
          check_field("movement_start", 32'(want.movement_start),
                      32'(out_data.movement_start));
          check_field("movement_stop", 32'(want.movement_stop),
                      32'(out_data.movement_stop));
          check_field("movement_update", 32'(want.movement_update),
                      32'(out_data.movement_update));
          check_field("movement_gain", 32'(want.movement_gain),
                      32'(out_data.movement_gain));
          check_field("movement_pitch", 32'(want.movement_pitch),
                      32'(out_data.movement_pitch));
          check_field("lower_hit", 32'(want.lower_hit), 32'(out_data.lower_hit));
          check_field("upper_hit", 32'(want.upper_hit), 32'(out_data.upper_hit));
          check_field("limit_gain", 32'(want.limit_gain), 32'(out_data.limit_gain));
          check_field("limit_pitch", 32'(want.limit_pitch), 32'(out_data.limit_pitch));
        end
      end
      if (in_valid && in_ready) begin
        predicted_sounds.insert(predicted_sounds.size(), compute_sound_events(in_data));
      end
      events_pending = predicted_sounds.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the joint motion sound trigger with position samples and checks it
// through jmst_checker. A short directed part walks movement start and stop,
// tiny motion, zero step time, saturated speed, limit hits and re-arming,
// both limits at once and disabled sounds. Random phases then reprogram the
// registers, extremes among them, and send motion that wanders around the
// bounds, with random idling on both channels, a long output stall and a
// pause of the input until every result has come back.
// ----------------------------------------------------------------------------
module tb;
  import jmst_pkg::*;

  // indexes past the register list, writes there are dropped
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE_POS = 32'sh0001_0000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 60;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  int fail_count;
  int events_pending;
  int tx_max_gap;
  int rx_max_gap;
  bit long_hold_req;
  logic signed [31:0] last_sent;
  logic signed [31:0] lower_lim;
  logic signed [31:0] upper_lim;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  joint_motion_sound_trigger u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  jmst_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .events_pending (events_pending)
  );

  // run limit
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stall after each taken item, or a long hold on request
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (out_valid && out_ready) begin
        stall = $urandom_range(0, rx_max_gap);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one sample after a random gap, return at the falling edge after it is taken
  task automatic offer_sample(input logic signed [31:0] pos, input logic [31:0] dt);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pos, dt};
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    last_sent = pos;
  endtask

  // stop offering and wait until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // program all registers, with junk in unused upper bits and at spare indexes
  task automatic program_regs(input logic signed [31:0] lb, input logic signed [31:0] ub,
                              input logic [63:0] mp, input logic [63:0] lp,
                              input logic [63:0] up, input logic [2:0] en);
    logic [63:0] noise;
    noise = {$urandom(), $urandom()};
    put_reg(REG_LOWER_BOUND, {noise[63:32], lb});
    put_reg(REG_UPPER_BOUND, {noise[31:0], ub});
    put_reg(REG_MOVEMENT_PARAM, mp);
    put_reg(REG_LOWER_PARAM, lp);
    put_reg(REG_UPPER_PARAM, up);
    put_reg(REG_SOUNDS_EN, {noise[63:3], en});
    put_reg(REG_SPARE_6, {$urandom(), $urandom()});
    put_reg(REG_SPARE_7, {$urandom(), $urandom()});
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    lower_lim = lb;
    upper_lim = ub;
  endtask

  // one parameter set, factors often small so gains are not always capped
  function automatic logic [63:0] random_params();
    logic [15:0] gf;
    logic [15:0] pf;
    gf = $urandom_range(0, 1) ? 16'($urandom_range(0, 'h3FF)) : 16'($urandom);
    pf = $urandom_range(0, 1) ? 16'($urandom_range(0, 'h3FF)) : 16'($urandom);
    return {gf, 16'($urandom), pf, 16'($urandom)};
  endfunction

  // motion that mostly wanders near the last position or a bound
  task automatic random_sample();
    logic signed [31:0] pos;
    logic [31:0]        dt;
    int                 delta;
    delta = int'($urandom_range(0, 'h80000)) - 'h40000;
    case ($urandom_range(0, 9))
      0:       pos = $urandom;
      1:       pos = last_sent;
      2, 3, 4: pos = last_sent + delta;
      5, 6:    pos = lower_lim + (delta >>> 1);
      7, 8:    pos = upper_lim + (delta >>> 1);
      default: begin
        case ($urandom_range(0, 2))
          0:       pos = POS_MIN;
          1:       pos = POS_MAX;
          default: pos = '0;
        endcase
      end
    endcase
    case ($urandom_range(0, 9))
      0:       dt = $urandom;
      1:       dt = '0;
      2:       dt = 32'd1;
      3:       dt = '1;
      default: dt = $urandom_range('h100, 'h40000);
    endcase
    offer_sample(pos, dt);
  endtask

  // stimulus and verdict
  initial begin
    logic signed [31:0] lb;
    logic signed [31:0] ub;
    logic signed [31:0] center;
    logic signed [31:0] span;
    logic [63:0]        mp;
    logic [2:0]         en;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_LOWER_BOUND;
    cfg_wdata = '0;
    tx_max_gap = 3;
    rx_max_gap = 3;
    long_hold_req = 1'b0;
    last_sent = '0;
    lower_lim = '0;
    upper_lim = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, all sounds off: speed extremes only
    offer_sample(ONE_POS, 32'h0001_0000);
    offer_sample(POS_MAX, 32'd1);
    offer_sample(POS_MIN, '1);
    offer_sample('0, '0);
    offer_sample('0, '0);

    // all sounds on, bounds at minus and plus one
    drain_results();
    program_regs(-ONE_POS, ONE_POS, 64'h0200_0800_0100_4000, 64'h0080_0400_0040_0200,
                 64'h4000_0300_0000_FFFF, 3'b111);
    offer_sample(32'sh8000, 32'h0001_0000);
    offer_sample(32'sh8000, 32'h0001_0000);
    offer_sample(32'sh8001, '1);
    offer_sample(32'sh3_0000, 32'h0001_0000);
    offer_sample(32'sh4_0000, 32'h0001_0000);
    offer_sample(32'sh4_0000, 32'h0001_0000);
    offer_sample('0, 32'h8000);
    offer_sample(32'sh2_0000, 32'h0001_0000);
    offer_sample(-32'sh3_0000, 32'h0001_0000);
    offer_sample(-32'sh3_8000, 32'h0002_0000);
    offer_sample('0, 32'h0001_0000);
    offer_sample(POS_MIN, 32'd1);
    offer_sample(POS_MAX, '0);

    // crossed bounds: re-arm each limit alone, then both fire together
    drain_results();
    program_regs(ONE_POS, -ONE_POS, PARAMS_RESET, '1, '0, 3'b010);
    offer_sample(32'sh2_0000, 32'h0001_0000);
    drain_results();
    program_regs(ONE_POS, -ONE_POS, PARAMS_RESET, '1, '0, 3'b100);
    offer_sample(-32'sh2_0000, 32'h0001_0000);
    drain_results();
    program_regs(ONE_POS, -ONE_POS, '1, 64'h0100_0200_0080_0180, '1, 3'b111);
    offer_sample('0, 32'h0001_0000);
    offer_sample('0, 32'h0001_0000);

    // random phases
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain_results();
      center = $urandom;
      span = $urandom_range(0, 'h80000);
      case (k)
        0: begin
          lb = POS_MIN;
          ub = POS_MAX;
        end
        1: begin
          lb = POS_MAX;
          ub = POS_MIN;
        end
        5: begin
          lb = center + span;
          ub = center - span;
        end
        default: begin
          lb = center - span;
          ub = center + span;
        end
      endcase
      mp = (k == 0) ? '1 : (k == 1) ? '0 : random_params();
      en = (k == 3) ? 3'b000 : (k == 6) ? 3'($urandom_range(1, 6)) : 3'b111;
      program_regs(lb, ub, mp, (k == 1) ? '1 : random_params(),
                   (k == 0) ? '0 : random_params(), en);
      tx_max_gap = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 3 : 18;
      rx_max_gap = ((k + 1) % 3 == 0) ? 0 : ((k + 1) % 3 == 1) ? 3 : 18;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 40 && (k == 2 || k == 5)) long_hold_req = 1'b1;
        if (n == 70 && k == 4) drain_results();
        random_sample();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
